### src/mrsi_pkg.sv
// ----------------------------------------------------------------------------
// mrsi_pkg
// Shared widths, field offsets and types for the moving rectangle sweep test.
// ----------------------------------------------------------------------------
package mrsi_pkg;

    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int LEAD_BITS  = COORD_BITS + 2;
    localparam int DIFF_BITS  = COORD_BITS + 3;
    localparam int VPROD_BITS = 2 * COORD_BITS;
    localparam int CROSS_BITS = 2 * COORD_BITS + 1;
    localparam int DEN_BITS   = 2 * COORD_BITS + 2;
    localparam int TPROD_BITS = DIFF_BITS + COORD_BITS;
    localparam int TERM_BITS  = TPROD_BITS + 1;

    localparam int RECT_BITS  = 4 * COORD_BITS + 2 * SIZE_BITS;
    localparam int IN_BITS    = 2 * RECT_BITS;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    localparam int OFF_X  = 0;
    localparam int OFF_Y  = OFF_X + COORD_BITS;
    localparam int OFF_W  = OFF_Y + COORD_BITS;
    localparam int OFF_H  = OFF_W + SIZE_BITS;
    localparam int OFF_VX = OFF_H + SIZE_BITS;
    localparam int OFF_VY = OFF_VX + COORD_BITS;
    localparam int OFF_B  = RECT_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vy;
        logic signed [COORD_BITS-1:0] vx;
        logic        [SIZE_BITS-1:0]  h;
        logic        [SIZE_BITS-1:0]  w;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_rect;

    typedef struct packed {
        logic                        moving;
        logic signed [LEAD_BITS-1:0] px;
        logic signed [LEAD_BITS-1:0] py;
    } t_lead;

endpackage

### src/mrsi_lead.sv
// ----------------------------------------------------------------------------
// mrsi_lead
// Leading point of one moving rectangle, in half-units, plus moving flag.
// ----------------------------------------------------------------------------
module mrsi_lead (
    input  mrsi_pkg::t_rect i_rect,
    output mrsi_pkg::t_lead o_lead
);

    function automatic logic signed [mrsi_pkg::LEAD_BITS-1:0] lead_coord(
        input logic signed [mrsi_pkg::COORD_BITS-1:0] c,
        input logic        [mrsi_pkg::SIZE_BITS-1:0]  s,
        input logic signed [mrsi_pkg::COORD_BITS-1:0] v
    );
        logic signed [mrsi_pkg::COORD_BITS:0]  sum;
        logic signed [mrsi_pkg::LEAD_BITS-1:0] near;
        logic signed [mrsi_pkg::LEAD_BITS-1:0] res;
        sum  = {c[mrsi_pkg::COORD_BITS-1], c} + {2'b00, s};
        near = {c[mrsi_pkg::COORD_BITS-1], c, 1'b0};
        if (v[mrsi_pkg::COORD_BITS-1]) begin
            res = near;
        end else if (v != '0) begin
            res = {sum, 1'b0};
        end else begin
            res = near + {3'b000, s};
        end
        return res;
    endfunction

    assign o_lead.moving = (i_rect.vx != '0) || (i_rect.vy != '0);
    assign o_lead.px     = lead_coord(i_rect.x, i_rect.w, i_rect.vx);
    assign o_lead.py     = lead_coord(i_rect.y, i_rect.h, i_rect.vy);

endmodule

### src/moving_rect_sweep_intersect.sv
// ----------------------------------------------------------------------------
// moving_rect_sweep_intersect
// Sweep test of the leading-point motion segments of two moving rectangles.
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one rectangle pair per item, master stream returns
//   one hit flag per item, in order.
//   pipeline of five register stages: leading points, offsets and velocity
//   cross terms, segment products, numerators and denominator, range check
//   into the output register. o_m_axis_tvalid rises once the item has passed
//   through all five registers.
//   throughput is one item per cycle while results are taken, set by the fully
//   pipelined multiply paths; there is no state between items.
//   reset empties all stages; o_s_axis_tready is high right after reset.
//   when the receiver holds i_m_axis_tready low with a result waiting, the
//   whole pipeline holds and o_s_axis_tready drops; nothing is lost or
//   repeated. bubbles in earlier stages are not squeezed out: the pipeline
//   only moves while the output stage is empty or being taken.
// ----------------------------------------------------------------------------
module moving_rect_sweep_intersect (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // a_x, a_y, a_width, a_height, a_vx, a_vy, b_x, b_y, b_width,
    // b_height, b_vx, b_vy, zero fill
    input  logic [mrsi_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // hit, zero fill
    output logic [mrsi_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int C  = mrsi_pkg::COORD_BITS;
    localparam int LB = mrsi_pkg::LEAD_BITS;
    localparam int DB = mrsi_pkg::DIFF_BITS;
    localparam int VB = mrsi_pkg::VPROD_BITS;
    localparam int XB = mrsi_pkg::CROSS_BITS;
    localparam int NB = mrsi_pkg::DEN_BITS;
    localparam int PB = mrsi_pkg::TPROD_BITS;
    localparam int TB = mrsi_pkg::TERM_BITS;

    mrsi_pkg::t_rect w_rect_a;
    mrsi_pkg::t_rect w_rect_b;
    mrsi_pkg::t_lead w_lead_a;
    mrsi_pkg::t_lead w_lead_b;
    logic            w_adv;

    assign w_rect_a = i_s_axis_tdata[mrsi_pkg::RECT_BITS-1:0];
    assign w_rect_b = i_s_axis_tdata[mrsi_pkg::OFF_B +: mrsi_pkg::RECT_BITS];

    mrsi_lead u_lead_a (
        .i_rect (w_rect_a),
        .o_lead (w_lead_a)
    );

    mrsi_lead u_lead_b (
        .i_rect (w_rect_b),
        .o_lead (w_lead_b)
    );

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1
    logic                 r1_ok;
    logic signed [LB-1:0] r1_pax, r1_pay, r1_pbx, r1_pby;
    logic signed [C-1:0]  r1_avx, r1_avy, r1_bvx, r1_bvy;
    // stage 2
    logic                 r2_ok;
    logic signed [DB-1:0] r2_dx, r2_dy;
    logic signed [VB-1:0] r2_c1, r2_c2;
    logic signed [C-1:0]  r2_avx, r2_avy, r2_bvx, r2_bvy;
    // stage 3
    logic                 r3_ok;
    logic signed [XB-1:0] r3_crs;
    logic signed [PB-1:0] r3_p1, r3_p2, r3_p3, r3_p4;
    // stage 4
    logic                 r4_ok;
    logic signed [TB-1:0] r4_t1, r4_t2;
    logic signed [NB-1:0] r4_den;
    // stage 5
    logic                 r5_hit;

    logic signed [DB-1:0] n_dx, n_dy;
    logic signed [XB-1:0] n_crs;
    logic signed [TB-1:0] n_t1, n_t2;
    logic signed [TB-1:0] w_den_ext;
    logic                 w_in1, w_in2;

    assign w_adv           = !r_v5 || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_v5;
    assign o_m_axis_tdata  = {{(mrsi_pkg::OUT_TDATA_W-1){1'b0}}, r5_hit};

    assign n_dx  = {r1_pbx[LB-1], r1_pbx} - {r1_pax[LB-1], r1_pax};
    assign n_dy  = {r1_pby[LB-1], r1_pby} - {r1_pay[LB-1], r1_pay};
    assign n_crs = {r2_c1[VB-1], r2_c1} - {r2_c2[VB-1], r2_c2};
    assign n_t1  = {r3_p1[PB-1], r3_p1} - {r3_p2[PB-1], r3_p2};
    assign n_t2  = {r3_p3[PB-1], r3_p3} - {r3_p4[PB-1], r3_p4};

    assign w_den_ext = {{(TB-NB){r4_den[NB-1]}}, r4_den};

    always_comb begin
        if (r4_den[NB-1]) begin
            w_in1 = (r4_t1 <= 0) && (r4_t1 >= w_den_ext);
            w_in2 = (r4_t2 <= 0) && (r4_t2 >= w_den_ext);
        end else begin
            w_in1 = (r4_t1 >= 0) && (r4_t1 <= w_den_ext);
            w_in2 = (r4_t2 >= 0) && (r4_t2 <= w_den_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ok  <= w_lead_a.moving && w_lead_b.moving;
            r1_pax <= w_lead_a.px;
            r1_pay <= w_lead_a.py;
            r1_pbx <= w_lead_b.px;
            r1_pby <= w_lead_b.py;
            r1_avx <= w_rect_a.vx;
            r1_avy <= w_rect_a.vy;
            r1_bvx <= w_rect_b.vx;
            r1_bvy <= w_rect_b.vy;

            r2_ok  <= r1_ok;
            r2_dx  <= n_dx;
            r2_dy  <= n_dy;
            r2_c1  <= r1_avx * r1_bvy;
            r2_c2  <= r1_avy * r1_bvx;
            r2_avx <= r1_avx;
            r2_avy <= r1_avy;
            r2_bvx <= r1_bvx;
            r2_bvy <= r1_bvy;

            r3_ok  <= r2_ok;
            r3_crs <= n_crs;
            r3_p1  <= r2_dx * r2_avy;
            r3_p2  <= r2_dy * r2_avx;
            r3_p3  <= r2_dx * r2_bvy;
            r3_p4  <= r2_dy * r2_bvx;

            r4_ok  <= r3_ok && (r3_crs != '0);
            r4_t1  <= n_t1;
            r4_t2  <= n_t2;
            r4_den <= {r3_crs, 1'b0};

            r5_hit <= r4_ok && w_in1 && w_in2;
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for moving_rect_sweep_intersect: rectangle pairs go in
// on the slave stream, each accepted pair gets its hit flag predicted in
// half-unit integer math, and the master stream is checked in order against
// those predictions under varying idle patterns and a long output hold.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef mrsi_pkg::t_rect t_rect;
    localparam int COORD_BITS  = mrsi_pkg::COORD_BITS;
    localparam int SIZE_BITS   = mrsi_pkg::SIZE_BITS;
    localparam int RECT_BITS   = mrsi_pkg::RECT_BITS;
    localparam int IN_BITS     = mrsi_pkg::IN_BITS;
    localparam int IN_TDATA_W  = mrsi_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = mrsi_pkg::OUT_TDATA_W;

    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_PAIRS = 180;

    class sweep_hit_board;
        bit expected_hits[$];
        int errors;
        int pairs;
        int results;
        int hits_seen;

        function bit leading_point(input t_rect r, output longint px, output longint py);
            longint x, y, w, h, vx, vy;
            x = $signed(r.x);
            y = $signed(r.y);
            w = r.w;
            h = r.h;
            vx = $signed(r.vx);
            vy = $signed(r.vy);
            px = 0;
            py = 0;
            if (vx == 0 && vy == 0)
                return 1'b0;
            px = (vx > 0) ? 2 * (x + w) : (vx < 0) ? 2 * x : 2 * x + w;
            py = (vy < 0) ? 2 * y : (vy > 0) ? 2 * (y + h) : 2 * y + h;
            return 1'b1;
        endfunction

        function bit unit_range(input longint num, input longint den);
            if (den > 0)
                return num >= 0 && num <= den;
            return num <= 0 && num >= den;
        endfunction

        function bit predict_hit(input t_rect a, input t_rect b);
            longint pax, pay, pbx, pby;
            longint avx, avy, bvx, bvy;
            longint cross_v, dx, dy, t_a, t_b;
            if (!leading_point(a, pax, pay))
                return 1'b0;
            if (!leading_point(b, pbx, pby))
                return 1'b0;
            avx = $signed(a.vx);
            avy = $signed(a.vy);
            bvx = $signed(b.vx);
            bvy = $signed(b.vy);
            cross_v = avx * bvy - avy * bvx;
            if (cross_v == 0)
                return 1'b0;
            dx = pbx - pax;
            dy = pby - pay;
            t_a = dx * avy - dy * avx;
            t_b = dx * bvy - dy * bvx;
            return unit_range(t_a, 2 * cross_v) && unit_range(t_b, 2 * cross_v);
        endfunction

        function void note_pair(input t_rect a, input t_rect b);
            expected_hits.push_back(predict_hit(a, b));
            pairs++;
        endfunction

        function void check_hit(input bit got);
            bit want;
            results++;
            hits_seen += got;
            if (expected_hits.size() == 0) begin
                $display("%0t: hit flag %0b arrived with none expected", $time, got);
                errors++;
                return;
            end
            want = expected_hits.pop_front();
            if (want != got) begin
                $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want, got);
                errors++;
            end
        endfunction

        function void close();
            if (expected_hits.size() != 0) begin
                $display("%0t: %0d hit flags never arrived", $time, expected_hits.size());
                errors += expected_hits.size();
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // a_x, a_y, a_width, a_height, a_vx, a_vy, b_x, b_y, b_width,
    // b_height, b_vx, b_vy, zero fill
    logic [IN_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // hit, zero fill
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    sweep_hit_board board = new;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;

    moving_rect_sweep_intersect DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side: check, random stalls, long hold on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_hit(o_m_axis_tdata[0]);
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    function automatic t_rect rect(input longint x, input longint y, input longint w,
                                   input longint h, input longint vx, input longint vy);
        t_rect r;
        r.x = COORD_BITS'(x);
        r.y = COORD_BITS'(y);
        r.w = SIZE_BITS'(w);
        r.h = SIZE_BITS'(h);
        r.vx = COORD_BITS'(vx);
        r.vy = COORD_BITS'(vy);
        return r;
    endfunction

    function automatic longint spread(input longint span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    function automatic longint pick_size(input longint span);
        int m;
        m = $urandom_range(19);
        if (m == 0)
            return 0;
        if (m == 1)
            return 32767;
        return longint'($urandom_range(span));
    endfunction

    function automatic void pick_motion(input longint span, output longint vx,
                                        output longint vy);
        vx = spread(span);
        vy = spread(span);
        case ($urandom_range(9))
            0: vx = 0;
            1: vy = 0;
            default: ;
        endcase
        if (vx == 0 && vy == 0)
            vx = 1;
    endfunction

    // rectangle whose leading point in the direction of motion is (lx, ly)
    function automatic t_rect from_lead(input longint lx, input longint ly, input longint w,
                                        input longint h, input longint vx, input longint vy);
        longint x, y;
        x = (vx > 0) ? lx - w : (vx < 0) ? lx : lx - w / 2;
        y = (vy < 0) ? ly : (vy > 0) ? ly - h : ly - h / 2;
        return rect(x, y, w, h, vx, vy);
    endfunction

    // two motion segments aimed at a common point, with small misses mixed in
    function automatic void make_crossing(output t_rect a, output t_rect b);
        longint span, avx, avy, bvx, bvy, lax, lay, lbx, lby, mx, my;
        longint aw, ah, bw, bh;
        int ka, kb, m;
        m = $urandom_range(19);
        span = (m < 14) ? 1000 : (m < 19) ? 8000 : 16000;
        pick_motion(span, avx, avy);
        pick_motion(span, bvx, bvy);
        if ($urandom_range(9) == 0) begin
            kb = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(1) + 1);
            bvx = avx * kb;
            bvy = avy * kb;
        end
        lax = spread(span);
        lay = spread(span);
        ka = $urandom_range(8);
        kb = $urandom_range(8);
        mx = lax + avx * ka / 8;
        my = lay + avy * ka / 8;
        lbx = mx - bvx * kb / 8;
        lby = my - bvy * kb / 8;
        if ($urandom_range(3) == 0) begin
            lbx += spread(2);
            lby += spread(2);
        end
        aw = pick_size(span);
        ah = pick_size(span);
        bw = pick_size(span);
        bh = pick_size(span);
        if ($urandom_range(4) == 0) begin
            bw = 0;
            bh = 0;
        end
        a = from_lead(lax, lay, aw, ah, avx, avy);
        b = from_lead(lbx, lby, bw, bh, bvx, bvy);
        m = $urandom_range(39);
        if (m == 0) begin
            a.vx = '0;
            a.vy = '0;
        end else if (m == 1) begin
            b.vx = '0;
            b.vy = '0;
        end
    endfunction

    function automatic void make_noise(output t_rect a, output t_rect b);
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        a = raw[RECT_BITS-1:0];
        raw = {$urandom, $urandom, $urandom};
        b = raw[RECT_BITS-1:0];
        if ($urandom_range(7) == 0) begin
            a.vx = '0;
            a.vy = '0;
        end
        if ($urandom_range(7) == 0) begin
            b.vx = '0;
            b.vy = '0;
        end
    endfunction

    task automatic send_pair(input t_rect a, input t_rect b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {{(IN_TDATA_W - IN_BITS){1'b0}}, b, a};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_pair(a, b);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.expected_hits.size() != 0);
    endtask

    task automatic run_directed();
        // both still, one still
        send_pair(rect(0, 0, 0, 0, 0, 0), rect(0, 0, 0, 0, 0, 0));
        send_pair(rect(0, 0, 5, 5, 0, 0), rect(2, -4, 0, 0, 0, 10));
        send_pair(rect(0, 0, 0, 0, 10, 10), rect(5, 5, 3, 3, 0, 0));
        // plain crossing of two points
        send_pair(rect(0, 0, 0, 0, 10, 10), rect(10, 0, 0, 0, -10, 10));
        // parallel and collinear overlap
        send_pair(rect(0, 0, 0, 0, 10, 0), rect(0, 3, 0, 0, 10, 0));
        send_pair(rect(0, 0, 0, 0, 10, 0), rect(5, 0, 0, 0, -10, 0));
        // segment ends touching exactly, and one unit past
        send_pair(rect(0, 0, 0, 0, 10, 0), rect(0, -5, 0, 0, 0, 5));
        send_pair(rect(0, 0, 0, 0, 10, 0), rect(10, -5, 0, 0, 0, 5));
        send_pair(rect(0, 0, 0, 0, 10, 0), rect(11, -5, 0, 0, 0, 5));
        send_pair(rect(0, 0, 0, 0, 10, 0), rect(5, -6, 0, 0, 0, 5));
        // edge midpoints, odd width puts the lead on a half unit
        send_pair(rect(0, 0, 4, 2, 0, 10), rect(6, 5, 0, 2, -10, 0));
        send_pair(rect(0, 0, 3, 2, 0, 10), rect(4, 5, 0, 0, -3, 0));
        send_pair(rect(0, 0, 3, 2, 0, 10), rect(4, 5, 0, 0, -2, 0));
        // upward motion into a point target
        send_pair(rect(-20, 10, 8, 6, 0, -30), rect(-30, -5, 0, 0, 30, 0));
        send_pair(rect(100, 100, 40, 20, -60, -60), rect(60, 40, 0, 0, 20, 80));
        // field extremes
        send_pair(rect(32767, 32767, 32767, 32767, 32767, 32767),
                  rect(-32768, -32768, 0, 0, -32768, -32768));
        send_pair(rect(-32768, -32768, 32767, 32767, -32768, 32767),
                  rect(32767, -32768, 32767, 0, 32767, -32768));
        send_pair(rect(-32768, 32767, 0, 32767, 32767, -32768),
                  rect(32767, 32767, 32767, 32767, -32768, 32767));
        send_pair(rect(-1, -1, 32767, 0, -1, 1), rect(-1, 0, 0, 32767, 1, 1));
        send_pair(rect(0, 0, 0, 0, -32768, 0), rect(-16384, -100, 0, 0, 0, 32767));
    endtask

    initial begin
        t_rect a, b;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        wait_drained();
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 84 : 0;
            rx_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 36 : 0;
            // hold results back while pairs keep coming, so the pipe backs up
            if (phase == 2)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_PAIRS; k++) begin
                if ($urandom_range(4) == 0)
                    make_noise(a, b);
                else
                    make_crossing(a, b);
                send_pair(a, b);
            end
            wait_drained();
        end
        repeat (10) @(posedge i_clk);
        board.close();
        $display("run: %0d rectangle pairs, %0d hit flags checked, %0d of them set",
                 board.pairs, board.results, board.hits_seen);
        $display("run: still, parallel, segment-end, midpoint and point-target cases %s",
                 "under three idle patterns and a long output hold");
        if (board.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
